// File: sv/tsp_pkg.sv
// Package for the timed slot pool: field widths, opcodes, event kinds
// and the controller state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

  localparam int OP_W    = 1;
  localparam int DUR_W   = 16;
  localparam int SND_W   = 16;
  localparam int SLOT_W  = 4;

  localparam logic [DUR_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic EV_START = 1'b0;
  localparam logic EV_STOP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TFLUSH,
    ST_SSTOP,
    ST_SSTART
  } tsp_state_e;

endpackage

`default_nettype wire

// File: sv/tsp_if.sv
// Valid/ready channel interfaces of the timed slot pool: request words in,
// event words out. Depends on tsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tsp_req_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [tsp_pkg::DUR_W-1:0] duration;
  logic [tsp_pkg::SND_W-1:0] sound_id;

  modport source (output valid, opcode, duration, sound_id, input ready);
  modport sink   (input valid, opcode, duration, sound_id, output ready);
endinterface

interface tsp_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       event_kind;
  logic [tsp_pkg::SLOT_W-1:0] slot_index;
  logic [tsp_pkg::SND_W-1:0]  started_sound;
  logic                       last;

  modport source (output valid, event_kind, slot_index, started_sound, last, input ready);
  modport sink   (input valid, event_kind, slot_index, started_sound, last, output ready);
endinterface

`default_nettype wire

// File: sv/tsp_slot_mem.sv
// Countdown memory of the slot pool: one write and one registered read port,
// with a per-entry written flag so that unwritten slots read as zero.
// Depends on tsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsp_slot_mem #(
  parameter int NUM_SLOTS = 16,
  parameter int IW        = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      rd_en_i,
  input  wire logic [IW-1:0]             rd_addr_i,
  output logic      [tsp_pkg::DUR_W-1:0] rd_data_o,
  input  wire logic                      wr_en_i,
  input  wire logic [IW-1:0]             wr_addr_i,
  input  wire logic [tsp_pkg::DUR_W-1:0] wr_data_i
);

  logic [tsp_pkg::DUR_W-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]      vld_q;
  logic [tsp_pkg::DUR_W-1:0] rdata_q;
  logic                      rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Reset frees every slot at once by dropping the written flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// File: sv/timed_slot_pool_evict_shortest.sv
// Timed slot pool: NUM_SLOTS countdowns, tick and start commands, stop and
// start events with eviction of the shortest-lived slot.
// Depends on tsp_pkg, tsp_req_if, tsp_rsp_if and tsp_slot_mem.
//
// Usage:
//   req_i takes one command word per handshake. A tick decrements every
//   running countdown and yields one stop word per slot that expires, or no
//   word at all. A start takes the first free slot, or evicts the
//   lowest-indexed slot with the smallest countdown (one stop word), and
//   then yields a start word. The final word of each command carries last.
//   Each command walks the countdown memory one slot per cycle through its
//   single read port, with the read-modify-write pipelined one slot behind,
//   except while a stalled rsp_o holds the scan. The block takes no new
//   command until the current one has finished and its last word has been
//   moved into the output register.
//   rsp_o is driven from an output register; a stalled receiver holds the
//   scan only when a new word must be moved into that register.
//   Reset is asynchronous and active low; it frees every slot at once and
//   drops any word in flight.
`timescale 1ns / 1ps
`default_nettype none

module timed_slot_pool_evict_shortest #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tsp_req_if.sink    req_i,
  tsp_rsp_if.source  rsp_o
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  tsp_pkg::tsp_state_e state_q, state_d;

  logic                        op_q;
  logic [tsp_pkg::DUR_W-1:0]   dur_q;
  logic [tsp_pkg::SND_W-1:0]   snd_q;

  logic [IW-1:0]               rd_idx_q;
  logic                        rd_done_q;
  logic                        rvalid_q;
  logic [IW-1:0]               pidx_q;

  logic                        pend_q;
  logic [IW-1:0]               pend_idx_q;
  logic                        free_q;
  logic [IW-1:0]               free_idx_q;
  logic [tsp_pkg::DUR_W-1:0]   best_q;
  logic [IW-1:0]               victim_q;

  logic                        out_vld_q;
  logic                        out_kind_q;
  logic [tsp_pkg::SLOT_W-1:0]  out_slot_q;
  logic [tsp_pkg::SND_W-1:0]   out_snd_q;
  logic                        out_last_q;

  logic                        accept;
  logic                        out_free;
  logic [tsp_pkg::DUR_W-1:0]   rd_val;
  logic                        expire;
  logic                        stall;
  logic                        consume;
  logic                        issue;
  logic                        scan_end;
  logic                        free_nx;
  logic [IW-1:0]               chosen;

  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [tsp_pkg::DUR_W-1:0]   wr_data;

  logic                        out_ld;
  logic                        out_kind_d;
  logic [IW-1:0]               out_idx_d;
  logic [tsp_pkg::SND_W-1:0]   out_snd_d;
  logic                        out_last_d;
  logic                        pend_set;
  logic                        pend_clr;

  tsp_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IW        (IW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (issue),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_val),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign req_i.ready = (state_q == tsp_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_vld_q || rsp_o.ready;

  assign expire   = (rd_val == 16'd1);
  // A second expiry can only be taken once the held one has moved out.
  assign stall    = rvalid_q && (op_q == tsp_pkg::OP_TICK) && expire && pend_q && !out_free;
  assign consume  = rvalid_q && !stall;
  assign issue    = (state_q == tsp_pkg::ST_SCAN) && !rd_done_q && (!rvalid_q || consume);
  assign scan_end = consume && (pidx_q == LAST_IDX);
  assign free_nx  = free_q || (rd_val == '0);
  assign chosen   = free_q ? free_idx_q : victim_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tsp_pkg::ST_SCAN;
        end
      end
      tsp_pkg::ST_SCAN: begin
        if (scan_end) begin
          if (op_q == tsp_pkg::OP_TICK) begin
            state_d = tsp_pkg::ST_TFLUSH;
          end else if (free_nx) begin
            state_d = tsp_pkg::ST_SSTART;
          end else begin
            state_d = tsp_pkg::ST_SSTOP;
          end
        end
      end
      tsp_pkg::ST_TFLUSH: begin
        if (!pend_q || out_free) begin
          state_d = tsp_pkg::ST_IDLE;
        end
      end
      tsp_pkg::ST_SSTOP: begin
        if (out_free) begin
          state_d = tsp_pkg::ST_SSTART;
        end
      end
      tsp_pkg::ST_SSTART: begin
        if (out_free) begin
          state_d = tsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsp_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory writes, event words and the held expiry.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = pidx_q;
    wr_data    = 16'(rd_val - 16'd1);
    out_ld     = 1'b0;
    out_kind_d = tsp_pkg::EV_STOP;
    out_idx_d  = pend_idx_q;
    out_snd_d  = '0;
    out_last_d = 1'b0;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    case (state_q)
      tsp_pkg::ST_SCAN: begin
        if (consume && (op_q == tsp_pkg::OP_TICK)) begin
          wr_en = (rd_val != '0);
          if (expire) begin
            pend_set = 1'b1;
            out_ld   = pend_q;
          end
        end
      end
      tsp_pkg::ST_TFLUSH: begin
        if (pend_q && out_free) begin
          out_ld     = 1'b1;
          out_last_d = 1'b1;
          pend_clr   = 1'b1;
        end
      end
      tsp_pkg::ST_SSTOP: begin
        out_ld    = out_free;
        out_idx_d = chosen;
      end
      tsp_pkg::ST_SSTART: begin
        wr_en      = out_free;
        wr_addr    = chosen;
        wr_data    = dur_q;
        out_ld     = out_free;
        out_kind_d = tsp_pkg::EV_START;
        out_idx_d  = chosen;
        out_snd_d  = snd_q;
        out_last_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.opcode;
      dur_q <= req_i.duration;
      snd_q <= req_i.sound_id;
    end
    if (issue) begin
      pidx_q <= rd_idx_q;
    end
    if (pend_set) begin
      pend_idx_q <= pidx_q;
    end
    if (consume && (op_q == tsp_pkg::OP_START)) begin
      if (!free_q && (rd_val == '0)) begin
        free_idx_q <= pidx_q;
      end
      if (rd_val < best_q) begin
        best_q   <= rd_val;
        victim_q <= pidx_q;
      end
    end
    if (accept) begin
      best_q   <= tsp_pkg::COUNT_MAX;
      victim_q <= '0;
    end
    if (out_ld) begin
      out_kind_q <= out_kind_d;
      out_slot_q <= tsp_pkg::SLOT_W'(out_idx_d);
      out_snd_q  <= out_snd_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tsp_pkg::ST_IDLE;
      rd_idx_q  <= '0;
      rd_done_q <= 1'b0;
      rvalid_q  <= 1'b0;
      pend_q    <= 1'b0;
      free_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rd_idx_q  <= '0;
        rd_done_q <= 1'b0;
        pend_q    <= 1'b0;
        free_q    <= 1'b0;
      end else begin
        if (issue) begin
          if (rd_idx_q == LAST_IDX) begin
            rd_done_q <= 1'b1;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
        end
        if (pend_set) begin
          pend_q <= 1'b1;
        end else if (pend_clr) begin
          pend_q <= 1'b0;
        end
        if (consume && (op_q == tsp_pkg::OP_START) && (rd_val == '0)) begin
          free_q <= 1'b1;
        end
      end
      if (issue) begin
        rvalid_q <= 1'b1;
      end else if (consume) begin
        rvalid_q <= 1'b0;
      end
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.event_kind    = out_kind_q;
  assign rsp_o.slot_index    = out_slot_q;
  assign rsp_o.started_sound = out_snd_q;
  assign rsp_o.last          = out_last_q;

  // The scan never reads the slot that is being written back.
  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && issue |-> wr_addr != rd_idx_q)
    else $error("read and write-back hit the same slot");

  // Nothing from the previous command is left over when a new one is taken.
  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tsp_pkg::ST_IDLE |-> !rvalid_q && !pend_q)
    else $error("command state left over in idle");

  // Read data is only outstanding while the scan runs.
  a_read_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> state_q == tsp_pkg::ST_SCAN)
    else $error("read data outstanding outside the scan");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for timed_slot_pool_evict_shortest: a queue-fed
// command driver, a randomly stalling event sink and a slot pool predictor.
// Depends on tsp_pkg, tsp_req_if, tsp_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb;

  localparam int          NUM_SLOTS   = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned RAND_CMDS   = 500;

  localparam int DUR_W  = tsp_pkg::DUR_W;
  localparam int SND_W  = tsp_pkg::SND_W;
  localparam int SLOT_W = tsp_pkg::SLOT_W;

  typedef struct packed {
    logic             opcode;
    logic [DUR_W-1:0] duration;
    logic [SND_W-1:0] sound_id;
  } pool_cmd_t;

  typedef struct packed {
    logic              event_kind;
    logic [SLOT_W-1:0] slot_index;
    logic [SND_W-1:0]  started_sound;
    logic              last;
  } pool_event_t;

  logic clk_i;
  logic rst_ni;

  tsp_req_if req_ch ();
  tsp_rsp_if rsp_ch ();

  timed_slot_pool_evict_shortest #(
    .NUM_SLOTS (NUM_SLOTS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  pool_cmd_t        pending_cmds[$];
  pool_event_t      expected_events[$];
  logic [DUR_W-1:0] slot_ticks[NUM_SLOTS];

  int unsigned cycle_count;
  int unsigned cmds_total;
  int unsigned cmds_accepted;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned tick_cmds;
  int unsigned start_cmds;
  int unsigned expiries;
  int unsigned evictions;

  int unsigned req_gap;
  int unsigned rsp_stall;
  logic        cmd_taken;
  logic        req_calm;
  logic        rsp_calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_draw(input logic calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Advances the slot pool by one command and queues the event words it causes.
  function automatic void pool_step(input pool_cmd_t c);
    logic [NUM_SLOTS-1:0] expired;
    logic [DUR_W-1:0]     best;
    pool_event_t          ev;
    int                   chosen;
    int                   victim;
    expired = '0;
    ev      = '0;
    if (c.opcode == tsp_pkg::OP_TICK) begin
      tick_cmds++;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_ticks[i] != '0) begin
          slot_ticks[i] = slot_ticks[i] - 1'b1;
          if (slot_ticks[i] == '0) expired[i] = 1'b1;
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (expired[i]) begin
          expired[i]       = 1'b0;
          ev.event_kind    = tsp_pkg::EV_STOP;
          ev.slot_index    = SLOT_W'(i);
          ev.started_sound = '0;
          ev.last          = (expired == '0);
          expected_events.push_back(ev);
          expiries++;
        end
      end
    end else begin
      start_cmds++;
      chosen = -1;
      victim = 0;
      best   = tsp_pkg::COUNT_MAX;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (chosen < 0) begin
          if (slot_ticks[i] == '0) begin
            chosen = i;
          end else if (slot_ticks[i] < best) begin
            best   = slot_ticks[i];
            victim = i;
          end
        end
      end
      // A full pool gives up its shortest countdown, slot 0 if all are at maximum.
      if (chosen < 0) begin
        chosen           = victim;
        ev.event_kind    = tsp_pkg::EV_STOP;
        ev.slot_index    = SLOT_W'(chosen);
        ev.started_sound = '0;
        ev.last          = 1'b0;
        expected_events.push_back(ev);
        evictions++;
      end
      slot_ticks[chosen] = c.duration;
      ev.event_kind      = tsp_pkg::EV_START;
      ev.slot_index      = SLOT_W'(chosen);
      ev.started_sound   = c.sound_id;
      ev.last            = 1'b1;
      expected_events.push_back(ev);
    end
  endfunction

  task automatic push_cmd(input logic op, input logic [DUR_W-1:0] dur,
                          input logic [SND_W-1:0] snd);
    pool_cmd_t c;
    c.opcode   = op;
    c.duration = dur;
    c.sound_id = snd;
    pending_cmds.push_back(c);
  endtask

  task automatic build_random();
    int unsigned made;
    int unsigned n;
    int unsigned tie_dur;
    made = 0;
    while (made < RAND_CMDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // Fill the pool and spill over, so that short countdowns get evicted.
          n = $urandom_range(12, 20);
          repeat (n) push_cmd(tsp_pkg::OP_START, DUR_W'($urandom_range(1, 8)),
                              SND_W'($urandom));
        end
        3, 4, 5: begin
          n = $urandom_range(1, 10);
          repeat (n) push_cmd(tsp_pkg::OP_TICK, DUR_W'($urandom), SND_W'($urandom));
        end
        6: begin
          // Equal durations expire together and tie on eviction.
          n       = $urandom_range(2, 6);
          tie_dur = $urandom_range(1, 4);
          repeat (n) push_cmd(tsp_pkg::OP_START, DUR_W'(tie_dur), SND_W'($urandom));
        end
        7: begin
          n = $urandom_range(1, 3);
          repeat (n) push_cmd(tsp_pkg::OP_START, '0, SND_W'($urandom));
        end
        8: begin
          n = 1;
          push_cmd(tsp_pkg::OP_START, DUR_W'($urandom_range(16'hFFF0, 16'hFFFF)),
                   SND_W'($urandom));
        end
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) push_cmd(1'($urandom), DUR_W'($urandom), SND_W'($urandom));
        end
      endcase
      made += n;
    end
  endtask

  // Command driver: holds a word until it is taken, then waits its drawn gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_ch.valid || cmd_taken) begin
        cmd_taken = 1'b0;
        if (req_gap > 0) begin
          req_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          req_ch.valid    <= 1'b1;
          req_ch.opcode   <= pending_cmds[0].opcode;
          req_ch.duration <= pending_cmds[0].duration;
          req_ch.sound_id <= pending_cmds[0].sound_id;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Event sink: stalls for a drawn number of cycles after each word.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        pool_step(pending_cmds.pop_front());
        cmds_accepted++;
        cmd_taken = 1'b1;
        if ($urandom_range(0, 39) == 0) req_calm = ~req_calm;
        req_gap = idle_draw(req_calm);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        words_checked++;
        if (expected_events.size() == 0) begin
          $error("event word with none expected: kind %0d slot %0d sound %0h last %0d",
                 rsp_ch.event_kind, rsp_ch.slot_index, rsp_ch.started_sound, rsp_ch.last);
          mismatches++;
        end else begin
          pool_event_t want;
          want = expected_events.pop_front();
          if (rsp_ch.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, rsp_ch.event_kind);
            mismatches++;
          end
          if (rsp_ch.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, rsp_ch.slot_index);
            mismatches++;
          end
          if (rsp_ch.started_sound !== want.started_sound) begin
            $error("started_sound: expected %0h, got %0h",
                   want.started_sound, rsp_ch.started_sound);
            mismatches++;
          end
          if (rsp_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
            mismatches++;
          end
        end
        if ($urandom_range(0, 39) == 0) rsp_calm = ~rsp_calm;
        rsp_stall = idle_draw(rsp_calm);
      end
    end
  end

  initial begin : main_seq
    int unsigned settle;
    rst_ni          = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = tsp_pkg::OP_TICK;
    req_ch.duration = '0;
    req_ch.sound_id = '0;
    rsp_ch.ready    = 1'b0;
    cycle_count     = 0;
    cmds_accepted   = 0;
    words_checked   = 0;
    mismatches      = 0;
    tick_cmds       = 0;
    start_cmds      = 0;
    expiries        = 0;
    evictions       = 0;
    req_gap         = 0;
    rsp_stall       = 0;
    cmd_taken       = 1'b0;
    req_calm        = 1'b0;
    rsp_calm        = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) slot_ticks[i] = '0;

    // Directed part: empty-pool tick, zero duration, a pool full of maximum
    // countdowns that must give up slot 0, then expiry and reuse of that slot.
    push_cmd(tsp_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
    push_cmd(tsp_pkg::OP_START, '0, 16'hFFFF);
    push_cmd(tsp_pkg::OP_TICK, '0, '0);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      push_cmd(tsp_pkg::OP_START, tsp_pkg::COUNT_MAX, SND_W'(16'h0100 + i));
    end
    push_cmd(tsp_pkg::OP_START, 16'h0001, 16'hA5A5);
    push_cmd(tsp_pkg::OP_TICK, '0, '0);
    push_cmd(tsp_pkg::OP_START, '0, '0);
    push_cmd(tsp_pkg::OP_START, 16'h0002, 16'h5A5A);
    build_random();
    cmds_total = pending_cmds.size();

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while ((cmds_accepted < cmds_total || expected_events.size() != 0) &&
           cycle_count < CYCLE_LIMIT)
      @(negedge clk_i);
    settle = 0;
    while (settle < SETTLE && cycle_count < CYCLE_LIMIT) begin
      @(negedge clk_i);
      settle++;
    end

    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run stopped at %0d cycles with %0d of %0d commands taken",
             cycle_count, cmds_accepted, cmds_total);
      mismatches++;
    end
    if (expected_events.size() != 0) begin
      $error("%0d event words never arrived", expected_events.size());
      mismatches++;
    end
    $display("Sent %0d commands (%0d ticks, %0d starts) in %0d cycles.",
             cmds_accepted, tick_cmds, start_cmds, cycle_count);
    $display("Checked %0d event words: %0d expiries, %0d evictions.",
             words_checked, expiries, evictions);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
